FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APU_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("apu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define APU_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("apu assertion failed");

`endif

FILE: rtl/apu_pkg.sv
`default_nettype none

package apu_pkg;

    parameter int CHANNELS   = 4;
    parameter int BYTE_W     = 8;
    parameter int PIX_W      = CHANNELS * BYTE_W;
    parameter int CFG_DATA_W = 16;
    parameter int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_IMAGE_WIDTH   = 2'd1,
        REG_IMAGE_HEIGHT  = 2'd2
    } t_cfg_reg;

    // per-item control handed to the predictor
    typedef struct packed {
        logic                first_row;
        logic                first_col;
        logic [CHANNELS-1:0] ch_en;
    } t_pred_ctl;

endpackage

`default_nettype wire

FILE: rtl/apu_predict.sv
`default_nettype none

module apu_predict
    import apu_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_residual,
    input  wire logic [PIX_W-1:0] i_left,
    input  wire logic [PIX_W-1:0] i_above,
    input  wire t_pred_ctl        i_ctl,
    output logic      [PIX_W-1:0] o_pixel
);

    always_comb begin
        logic [BYTE_W-1:0] res;
        logic [BYTE_W-1:0] lft;
        logic [BYTE_W-1:0] abv;
        logic [BYTE_W:0]   sum;
        logic [BYTE_W-1:0] pred;
        o_pixel = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            res = i_residual[c*BYTE_W +: BYTE_W];
            lft = i_left[c*BYTE_W +: BYTE_W];
            abv = i_above[c*BYTE_W +: BYTE_W];
            sum = {1'b0, lft} + {1'b0, abv};
            if (i_ctl.first_row && i_ctl.first_col) begin
                pred = '0;
            end else if (i_ctl.first_row) begin
                pred = lft;
            end else if (i_ctl.first_col) begin
                pred = abv;
            end else begin
                pred = sum[BYTE_W:1];
            end
            if (i_ctl.ch_en[c]) begin
                o_pixel[c*BYTE_W +: BYTE_W] = res + pred;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/average_predictor_unfilter.sv
// Average-prediction unfilter, one pixel of up to four channel bytes per item.
// Input channel: i_in_valid / o_in_ready with four residual bytes, raster order.
// Output channel: o_out_valid / i_out_ready with four pixel bytes plus
// end-of-row and end-of-image flags.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 channel count, 1 image width, 2 image height); write only when idle.
// A result passes through the read stage and the output register before it is valid.
// Throughput: one item per cycle while i_out_ready is held high. The line
// memory is read at acceptance and written back when the item leaves the read
// stage; when the next item reads the entry being written (one-pixel-wide
// images) the above value is taken from the left pixel register instead.
// Reset: registers return to 3 channels, width 4096, height 1; position
// goes to the first pixel. Line memory content is not cleared.
// Stall: the output register holds its item while i_out_ready is low; one
// more item can be accepted into the read stage, then o_in_ready drops.
`default_nettype none

module average_predictor_unfilter
    import apu_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [BYTE_W-1:0]     i_residual_0,
    input  wire logic [BYTE_W-1:0]     i_residual_1,
    input  wire logic [BYTE_W-1:0]     i_residual_2,
    input  wire logic [BYTE_W-1:0]     i_residual_3,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [BYTE_W-1:0]          o_pixel_0,
    output logic [BYTE_W-1:0]          o_pixel_1,
    output logic [BYTE_W-1:0]          o_pixel_2,
    output logic [BYTE_W-1:0]          o_pixel_3,
    output logic                       o_end_of_row,
    output logic                       o_end_of_image
);

    localparam int          AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);

    // configuration
    logic [2:0]  r_channel_count;
    logic [12:0] r_image_width;
    logic [15:0] r_image_height;

    // position
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;

    // read stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_res;
    t_pred_ctl        r_s1_ctl;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_eor;
    logic             r_s1_eoi;
    logic             r_fwd;

    // line memory
    logic [PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_rd;

    // output stage
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_eor;
    logic             r_out_eoi;
    logic [PIX_W-1:0] r_left;

    logic [CHANNELS-1:0] ch_mask;
    logic [16:0]         w_eff;
    logic [16:0]         h_eff;
    logic                last_col;
    logic                last_row;
    logic                accept;
    logic                s1_adv;
    logic [PIX_W-1:0]    above;
    logic [PIX_W-1:0]    pix_word;
    logic [AW-1:0]       n_col;
    logic [15:0]         n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 3'd3;
            r_image_width   <= 13'd4096;
            r_image_height  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                REG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_channel_count) inside
            3'd0, 3'd1: ch_mask = 4'b0001;
            3'd2:       ch_mask = 4'b0011;
            3'd3:       ch_mask = 4'b0111;
            default:    ch_mask = 4'b1111;
        endcase
    end

    always_comb begin
        if (r_image_width == 13'd0) begin
            w_eff = 17'd1;
        end else if (17'(r_image_width) > MAX_W17) begin
            w_eff = MAX_W17;
        end else begin
            w_eff = 17'(r_image_width);
        end
        h_eff = (r_image_height == 16'd0) ? 17'd1 : 17'(r_image_height);
    end

    assign last_col = (17'(r_col) + 17'd1) >= w_eff;
    assign last_row = (17'(r_row) + 17'd1) >= h_eff;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? 16'd0 : r_row + 16'd1;
        end else begin
            n_col = r_col + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res           <= {i_residual_3, i_residual_2, i_residual_1, i_residual_0};
            r_s1_ctl.first_row <= (r_row == 16'd0);
            r_s1_ctl.first_col <= (r_col == '0);
            r_s1_ctl.ch_en     <= ch_mask;
            r_s1_addr          <= r_col;
            r_s1_eor           <= last_col;
            r_s1_eoi           <= last_col && last_row;
            // entry written back this same edge: memory returns stale data
            r_fwd              <= s1_adv && (r_s1_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_mem[r_s1_addr] <= pix_word;
        end
        if (accept) begin
            r_line_rd <= r_line_mem[r_col];
        end
    end

    // the previous item's result is the left pixel
    assign above = r_fwd ? r_left : r_line_rd;

    apu_predict u_predict (
        .i_residual (r_s1_res),
        .i_left     (r_left),
        .i_above    (above),
        .i_ctl      (r_s1_ctl),
        .o_pixel    (pix_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_left      <= pix_word;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix <= pix_word;
            r_out_eor <= r_s1_eor;
            r_out_eoi <= r_s1_eoi;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_0      = r_out_pix[0*BYTE_W +: BYTE_W];
    assign o_pixel_1      = r_out_pix[1*BYTE_W +: BYTE_W];
    assign o_pixel_2      = r_out_pix[2*BYTE_W +: BYTE_W];
    assign o_pixel_3      = r_out_pix[3*BYTE_W +: BYTE_W];
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;

endmodule

`default_nettype wire

FILE: rtl/apu_checker.sv
`default_nettype none
`include "assert_macros.svh"

module apu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_pixel_0,
    input wire logic [7:0] o_pixel_1,
    input wire logic [7:0] o_pixel_2,
    input wire logic [7:0] o_pixel_3,
    input wire logic       o_end_of_row,
    input wire logic       o_end_of_image
);

    logic [33:0] out_word;

    assign out_word = {o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0,
                       o_end_of_row, o_end_of_image};

    `APU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `APU_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(out_word))

    // the last pixel of the image is always the last of its row
    `APU_ASSERT_IMP(a_eoi_eor, i_clk, i_rst_n, o_out_valid && o_end_of_image, o_end_of_row)

    // with the output register empty nothing can block the input
    `APU_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind average_predictor_unfilter apu_checker u_apu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pixel_0      (o_pixel_0),
    .o_pixel_1      (o_pixel_1),
    .o_pixel_2      (o_pixel_2),
    .o_pixel_3      (o_pixel_3),
    .o_end_of_row   (o_end_of_row),
    .o_end_of_image (o_end_of_image)
);

`default_nettype wire
